// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define PSU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PSU_ASSERT(lbl, prop)
`define PSU_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/psu_pkg.sv =====
// shared constants, codes and types of the path matching state update block
// no dependencies
`timescale 1ns / 1ps
package psu_pkg;
  localparam int STORE_SLOTS_DEF   = 16;
  localparam int TWO_EDGE_CODE_DEF = 255;

  localparam logic [2:0] ACT_LOAD   = 3'd0;
  localparam logic [2:0] ACT_ADDV   = 3'd1;
  localparam logic [2:0] ACT_AVAIL  = 3'd2;
  localparam logic [2:0] ACT_CHOSEN = 3'd3;
  localparam logic [2:0] ACT_DEL    = 3'd4;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_REJ   = 2'd2;

  // how a pass rewrites each slot
  localparam logic [2:0] MODE_ADDV = 3'd0;
  localparam logic [2:0] MODE_DEL  = 3'd1;
  localparam logic [2:0] MODE_COPY = 3'd2;
  localparam logic [2:0] MODE_FIN  = 3'd3;
  localparam logic [2:0] MODE_JOIN = 3'd4;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] v;
    logic [3:0] w;
    logic [3:0] bs;
    logic [7:0] vm;
    logic [7:0] wm;
  } xf_ctl_t;
endpackage

// ===== hw/rtl/path_matching_state_update.sv =====
// top level: operation sequencer around the match and branch state memories
// depends on psu_pkg, psu_mem, psu_xform and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
//  channel | dir | handshake           | contents
//  in_     | in  | tvalid/tready       | tuser action, tdata operands
//  out_    | out | tvalid/tready/tlast | tuser kind and solution, tdata slot and entry
//  a load writes one entry and acknowledges; any other operation first scans all
//  slots, then streams each result state over every slot, once more with a
//  branched state; a rejected operation ends after the scan with a reject word.
//  each slot is handled as a read, then a modify/write of the memory, and a new
//  operation is taken only once the current one is done.
//  synchronous active-low reset clears control state and the memory valid bits.
//  an output stall freezes the pass at the current slot until the word is taken.
module path_matching_state_update #(
  parameter int STORE_SLOTS   = psu_pkg::STORE_SLOTS_DEF,
  parameter int TWO_EDGE_CODE = psu_pkg::TWO_EDGE_CODE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] position, [11:4] value, [15:12] vertex_a, [19:16] vertex_b,
  // [23:20] bag_size, [24] closing edge flag, rest zero
  input  logic [31:0] in_tdata,
  // [2:0] action
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] slot, [11:4] entry, rest zero
  output logic [15:0] out_tdata,
  // [1:0] kind, [2] solution_index
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);
  localparam int AW = $clog2(STORE_SLOTS);
  localparam int CW = $clog2(STORE_SLOTS + 1);
  localparam int STREAM_SLOTS = (STORE_SLOTS < 16) ? STORE_SLOTS : 16;
  localparam logic [7:0] SL8 = 8'(STORE_SLOTS);
  localparam logic [7:0] ST8 = 8'(STREAM_SLOTS);
  localparam logic [7:0] TWO = 8'(TWO_EDGE_CODE);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACK  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_REJ  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] act_r, act_nxt;
  logic [3:0] pos_r, pos_nxt, v_r, v_nxt, w_r, w_nxt, bs_r, bs_nxt;
  logic [7:0] val_r, val_nxt;
  logic       fin_r, fin_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic       pre_r, pre_nxt, close_ok_r, close_ok_nxt;
  logic [7:0] vm_r, vm_nxt, wm_r, wm_nxt, prev_r, prev_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic       sol_r, sol_nxt, cm_r, cm_nxt, cb_r, cb_nxt;
  logic       lastp_r, lastp_nxt, tjoin_r, tjoin_nxt;
  logic       ov_r, ov_nxt, osol_r, osol_nxt, olast_r, olast_nxt;
  logic [1:0] okind_r, okind_nxt;
  logic [3:0] oslot_r, oslot_nxt;
  logic [7:0] oentry_r, oentry_nxt;

  logic          out_free, adv, in_fire, last_idx, rej, joinable;
  logic [7:0]    idx8, v8, w8, bs8, cur, nxt, nv;
  logic          m_we, m_re;
  logic [AW-1:0] m_wa, ra0, ra1;
  logic [7:0]    m_wd;
  logic          b_we;
  logic [7:0]    branch_mem [STORE_SLOTS];
  psu_pkg::xf_ctl_t ctl;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !ov_r || out_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, oentry_r, oslot_r};
  assign out_tuser  = {osol_r, okind_r};
  assign out_tlast  = olast_r;

  assign idx8 = 8'(idx_r);
  assign v8   = {4'd0, v_r};
  assign w8   = {4'd0, w_r};
  assign bs8  = {4'd0, bs_r};
  assign last_idx = (idx_r == CW'(STORE_SLOTS - 1));
  assign adv = pre_r || (idx8 >= ST8) || out_free;

  assign ra0  = idx_r[AW-1:0];
  assign ra1  = AW'(idx_r + CW'(1));
  assign m_re = (state_r == S_RD);
  assign m_we = ((state_r == S_EMIT) && !pre_r && cm_r && adv) ||
                ((state_r == S_ACK) && out_free && ({4'd0, pos_r} < SL8));
  assign m_wa = (state_r == S_ACK) ? AW'(pos_r) : idx_r[AW-1:0];
  assign m_wd = (state_r == S_ACK) ? val_r : nv;
  assign b_we = (state_r == S_EMIT) && !pre_r && cb_r && adv;

  psu_mem #(.DEPTH(STORE_SLOTS)) u_match (
    .clk(clk), .rst_n(rst_n), .we(m_we), .wa(m_wa), .wd(m_wd),
    .re(m_re), .ra0(ra0), .ra1(ra1), .rd0(cur), .rd1(nxt)
  );

  assign ctl = '{mode: mode_r, v: v_r, w: w_r, bs: bs_r, vm: vm_r, wm: wm_r};

  psu_xform #(.TWO_EDGE_CODE(TWO_EDGE_CODE)) u_xform (
    .ctl(ctl), .idx(idx8), .cur(cur), .nxt(nxt), .prev(prev_r), .nv(nv)
  );

  // branched state is kept but never read back
  always_ff @(posedge clk) begin
    if (b_we) begin
      branch_mem[idx_r[AW-1:0]] <= nv;
    end
  end

  assign joinable = (vm_r != TWO) && (wm_r != TWO) && (vm_r != w8);

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r; pos_nxt = pos_r; val_nxt = val_r; v_nxt = v_r; w_nxt = w_r;
    bs_nxt = bs_r; fin_nxt = fin_r;
    idx_nxt = idx_r; pre_nxt = pre_r; close_ok_nxt = close_ok_r;
    vm_nxt = vm_r; wm_nxt = wm_r; prev_nxt = prev_r;
    mode_nxt = mode_r; sol_nxt = sol_r; cm_nxt = cm_r; cb_nxt = cb_r;
    lastp_nxt = lastp_r; tjoin_nxt = tjoin_r;
    ov_nxt = ov_r && !out_tready;
    okind_nxt = okind_r; osol_nxt = osol_r; oslot_nxt = oslot_r;
    oentry_nxt = oentry_r; olast_nxt = olast_r;
    rej = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt = in_tuser;
          pos_nxt = in_tdata[3:0];
          val_nxt = in_tdata[11:4];
          v_nxt   = in_tdata[15:12];
          w_nxt   = in_tdata[19:16];
          bs_nxt  = in_tdata[23:20];
          fin_nxt = in_tdata[24];
          idx_nxt = '0;
          pre_nxt = 1'b1;
          close_ok_nxt = 1'b1;
          state_nxt = (in_tuser == psu_pkg::ACT_LOAD) ? S_ACK : S_RD;
        end
      end
      S_ACK: begin
        if (out_free) begin
          ov_nxt = 1'b1; okind_nxt = psu_pkg::KIND_ACK; osol_nxt = 1'b0;
          oslot_nxt = pos_r; oentry_nxt = val_r; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (adv) begin
          if (pre_r) begin
            // cycle closing check over the bag
            if (idx8 < bs8) begin
              if ((cur != TWO && idx8 != v8 && idx8 != w8) ||
                  (idx8 == v8 && cur != w8) || (idx8 == w8 && cur != v8)) begin
                close_ok_nxt = 1'b0;
              end
            end
            if (idx8 == v8) vm_nxt = cur;
            if (idx8 == w8) wm_nxt = cur;
          end else if (idx8 < ST8) begin
            ov_nxt = 1'b1; okind_nxt = psu_pkg::KIND_ENTRY; osol_nxt = sol_r;
            oslot_nxt = idx_r[3:0]; oentry_nxt = nv;
            olast_nxt = lastp_r && (idx8 == ST8 - 8'd1);
          end
          prev_nxt = cur;
          if (last_idx) begin
            idx_nxt = '0;
            if (pre_r) begin
              pre_nxt = 1'b0;
              state_nxt = S_DEC;
            end else if (tjoin_r) begin
              tjoin_nxt = 1'b0; mode_nxt = psu_pkg::MODE_JOIN; sol_nxt = 1'b1;
              cm_nxt = 1'b0; cb_nxt = 1'b1; lastp_nxt = 1'b1;
              state_nxt = S_RD;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            idx_nxt = idx_r + CW'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_DEC: begin
        sol_nxt = 1'b0; cm_nxt = 1'b1; cb_nxt = 1'b0; lastp_nxt = 1'b1;
        tjoin_nxt = 1'b0; mode_nxt = psu_pkg::MODE_COPY;
        unique case (act_r) inside
          psu_pkg::ACT_ADDV: begin
            rej = (bs_r == 4'd0) || (bs8 > SL8) || (v_r >= bs_r);
            mode_nxt = psu_pkg::MODE_ADDV;
          end
          psu_pkg::ACT_AVAIL, psu_pkg::ACT_CHOSEN: begin
            if ((bs8 > SL8) || (v_r >= bs_r) || (w_r >= bs_r)) begin
              rej = 1'b1;
            end else if (fin_r && close_ok_r) begin
              mode_nxt = psu_pkg::MODE_FIN;
            end else if (!joinable) begin
              rej = (act_r == psu_pkg::ACT_CHOSEN);
              cm_nxt = 1'b0;
            end else if ((vm_r >= SL8) || (wm_r >= SL8)) begin
              rej = 1'b1;
            end else if (act_r == psu_pkg::ACT_CHOSEN) begin
              mode_nxt = psu_pkg::MODE_JOIN;
            end else begin
              cm_nxt = 1'b0; lastp_nxt = 1'b0; tjoin_nxt = 1'b1;
            end
          end
          psu_pkg::ACT_DEL: begin
            rej = (bs_r == 4'd0) || (bs8 >= SL8) || (v_r >= bs_r) || (vm_r != TWO);
            mode_nxt = psu_pkg::MODE_DEL;
          end
          default: rej = 1'b1;
        endcase
        idx_nxt = '0;
        state_nxt = rej ? S_REJ : S_RD;
      end
      S_REJ: begin
        if (out_free) begin
          ov_nxt = 1'b1; okind_nxt = psu_pkg::KIND_REJ; osol_nxt = 1'b0;
          oslot_nxt = 4'd0; oentry_nxt = 8'd0; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      idx_r   <= '0;
      pre_r   <= 1'b0;
      tjoin_r <= 1'b0;
      cm_r    <= 1'b0;
      cb_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      idx_r   <= idx_nxt;
      pre_r   <= pre_nxt;
      tjoin_r <= tjoin_nxt;
      cm_r    <= cm_nxt;
      cb_r    <= cb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt; pos_r <= pos_nxt; val_r <= val_nxt; v_r <= v_nxt;
    w_r <= w_nxt; bs_r <= bs_nxt; fin_r <= fin_nxt;
    close_ok_r <= close_ok_nxt; vm_r <= vm_nxt; wm_r <= wm_nxt; prev_r <= prev_nxt;
    mode_r <= mode_nxt; sol_r <= sol_nxt; lastp_r <= lastp_nxt;
    okind_r <= okind_nxt; osol_r <= osol_nxt; oslot_r <= oslot_nxt;
    oentry_r <= oentry_nxt; olast_r <= olast_nxt;
  end

  `PSU_ASSERT(a_rd_then_emit, (state_r == S_RD) |=> (state_r == S_EMIT))
  `PSU_ASSERT(a_we_phase, m_we |-> (state_r == S_EMIT || state_r == S_ACK))
  `PSU_ASSERT(a_branch_sol, b_we |-> (sol_r && !cm_r))
  `PSU_ASSERT(a_rej_last, (ov_r && okind_r == psu_pkg::KIND_REJ) |-> olast_r)
endmodule

// ===== hw/rtl/psu_mem.sv =====
// state memory: one write port, two registered read ports, per-entry valid bits
// depends on nothing; entries never written read as zero
`timescale 1ns / 1ps
module psu_mem #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [7:0]    wd,
  input  logic          re,
  input  logic [AW-1:0] ra0,
  input  logic [AW-1:0] ra1,
  output logic [7:0]    rd0,
  output logic [7:0]    rd1
);
  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd0 <= valid_r[ra0] ? mem[ra0] : 8'd0;
      rd1 <= valid_r[ra1] ? mem[ra1] : 8'd0;
    end
  end
endmodule

// ===== hw/rtl/psu_xform.sv =====
// per-slot rewrite of one state entry for each operation
// depends on psu_pkg
`timescale 1ns / 1ps
module psu_xform #(
  parameter int TWO_EDGE_CODE = psu_pkg::TWO_EDGE_CODE_DEF
) (
  input  psu_pkg::xf_ctl_t ctl,
  input  logic [7:0]       idx,
  input  logic [7:0]       cur,
  input  logic [7:0]       nxt,
  input  logic [7:0]       prev,
  output logic [7:0]       nv
);
  localparam logic [7:0] TWO = 8'(TWO_EDGE_CODE);
  logic [7:0] v8, w8, bs8, up_prev, up_cur, dn_cur, dn_nxt;

  assign v8  = {4'd0, ctl.v};
  assign w8  = {4'd0, ctl.w};
  assign bs8 = {4'd0, ctl.bs};
  assign up_prev = (prev >= v8 && prev != TWO) ? prev + 8'd1 : prev;
  assign up_cur  = (cur >= v8 && cur != TWO) ? cur + 8'd1 : cur;
  assign dn_cur  = (cur > v8 && cur != TWO) ? cur - 8'd1 : cur;
  assign dn_nxt  = (nxt > v8 && nxt != TWO) ? nxt - 8'd1 : nxt;

  always_comb begin
    unique case (ctl.mode)
      psu_pkg::MODE_ADDV: begin
        if (idx >= bs8)      nv = cur;
        else if (idx > v8)   nv = up_prev;
        else if (idx == v8)  nv = v8;
        else                 nv = up_cur;
      end
      psu_pkg::MODE_DEL: begin
        if (idx < v8)        nv = dn_cur;
        else if (idx < bs8)  nv = dn_nxt;
        else if (idx == bs8) nv = 8'd0;
        else                 nv = cur;
      end
      psu_pkg::MODE_FIN: nv = (idx == v8 || idx == w8) ? TWO : cur;
      psu_pkg::MODE_JOIN: begin
        if (idx == ctl.wm)                      nv = ctl.vm;
        else if (idx == ctl.vm)                 nv = ctl.wm;
        else if (idx == w8 && ctl.wm != w8)     nv = TWO;
        else if (idx == v8 && ctl.vm != v8)     nv = TWO;
        else                                    nv = cur;
      end
      default: nv = cur;
    endcase
  end
endmodule
